// File: rtl/core/ilp_pkg.sv
// Shared types, character codes and helper functions for the integer literal parser.
// No dependencies; integer_literal_parser.sv refers to it by scoped names.
package ilp_pkg;

  // Literal kind codes on the result beat
  localparam logic [2:0] KIND_HEX  = 3'd0;
  localparam logic [2:0] KIND_DEC  = 3'd1;
  localparam logic [2:0] KIND_CHAR = 3'd2;
  localparam logic [2:0] KIND_BOOL = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;

  // Number form tracked while the token streams in
  localparam logic [1:0] FORM_OTHER = 2'd0;
  localparam logic [1:0] FORM_DEC   = 2'd1;
  localparam logic [1:0] FORM_HEX   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;

  // Boolean words: the first TRUE_WORDS entries mean 1, the rest mean 0
  localparam int unsigned WORD_COUNT = 6;
  localparam int unsigned TRUE_WORDS = 3;
  localparam int unsigned WORD_SLOTS = 8;

  typedef logic [WORD_COUNT-1:0] word_mask_t;

  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_SLOTS] = '{
    '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // true
    '{8'h54, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // True
    '{8'h54, 8'h52, 8'h55, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},  // TRUE
    '{8'h66, 8'h61, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},  // false
    '{8'h46, 8'h61, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},  // False
    '{8'h46, 8'h41, 8'h4c, 8'h53, 8'h45, 8'h00, 8'h00, 8'h00}   // FALSE
  };

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5
  };

  // Hex digit decode result
  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } hex_digit_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.hit = 1'b0;
    r.val = 4'd0;
    if (is_dec(c)) begin
      r.hit = 1'b1;
      r.val = c[3:0];
    end else if (((c >= CH_A_LO) && (c <= CH_F_LO)) || ((c >= CH_A_UP) && (c <= CH_F_UP))) begin
      // a..f and A..F both carry 1..6 in the low nibble
      r.hit = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ilp_in_if.sv
// Character channel of the integer literal parser: one token byte per beat.
// No dependencies.
interface ilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: rtl/core/ilp_out_if.sv
// Result channel of the integer literal parser: one beat per finished token.
// No dependencies; VALUE_WIDTH sets the width of the converted value.
interface ilp_out_if #(
  parameter int unsigned VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [2:0]             literal_kind;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output ok, output literal_kind, output negative,
                  output value, input ready);
  modport sink   (input valid, input ok, input literal_kind, input negative,
                  input value, output ready);
endinterface

// File: rtl/core/integer_literal_parser.sv
// Top level of the integer literal parser: token state, digit accumulator, result register.
// Depends on ilp_pkg, ilp_in_if and ilp_out_if.
//
//  channel | dir | payload                              | beat
//  in_i    | in  | ch[7:0], last                        | one token character
//  out_o   | out | ok, literal_kind[2:0], negative,     | one result per token,
//          |     | value[VALUE_WIDTH-1:0]               | after the last character
//
// One character per cycle while in_i.ready is high. The result of a token is registered
// at the edge that accepts its last character and is offered on out_o from the next cycle on.
// The digit step (times 10 or 16 by shift-add, plus digit, overflow check on the
// carry bits) sits between the state registers and the result register.
// in_i.ready drops only while a result waits and out_o.ready is low.
// Reset clears the token state and empties the result register.
module integer_literal_parser #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ilp_in_if.sink         in_i,
  ilp_out_if.source      out_o
);

  localparam int unsigned SUM_W = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] NEG_LIM = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Token state
  logic [2:0]             pos_q, pos_d;
  logic [1:0]             form_q, form_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   minus_q, minus_d;
  logic                   ovf_q, ovf_d;
  logic                   derr_q, derr_d;
  logic [7:0]             first_q, first_d;
  logic [7:0]             second_q, second_d;
  ilp_pkg::word_mask_t    wmatch_q, wmatch_d;

  // Result register
  logic                   out_valid_q;
  logic                   res_ok_q, res_ok_d;
  logic [2:0]             res_kind_q, res_kind_d;
  logic                   res_neg_q, res_neg_d;
  logic [VALUE_WIDTH-1:0] res_val_q, res_val_d;

  logic                   accept;
  logic [3:0]             len;
  logic                   do_acc;
  logic                   use_hex;
  logic [3:0]             digit;
  logic [SUM_W-1:0]       acc_scaled;
  logic [SUM_W-1:0]       acc_sum;
  ilp_pkg::hex_digit_t    hexd;
  logic                   word_hit;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign len        = {1'b0, pos_q} + 4'd1;
  assign hexd       = ilp_pkg::hex_decode(in_i.ch);

  // Pick radix and digit from the form held so far
  assign use_hex    = (form_q == ilp_pkg::FORM_HEX);
  assign digit      = use_hex ? hexd.val : in_i.ch[3:0];

  // Scale the accumulator by 16 or by 10 (8x + 2x), then add the digit
  assign acc_scaled = use_hex ? {acc_q, 4'b0000}
                              : ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0});
  assign acc_sum    = acc_scaled + {{(SUM_W-4){1'b0}}, digit};

  // Advance the token state by one character
  always_comb begin
    pos_d    = pos_q;
    form_d   = form_q;
    acc_d    = acc_q;
    minus_d  = minus_q;
    ovf_d    = ovf_q;
    derr_d   = derr_q;
    first_d  = first_q;
    second_d = second_q;
    do_acc   = 1'b0;

    // Drop every word that disagrees at this position or is already complete
    for (int i = 0; i < ilp_pkg::WORD_COUNT; i++) begin
      wmatch_d[i] = wmatch_q[i] && (len <= ilp_pkg::WORD_LEN[i])
                    && (ilp_pkg::WORD_TEXT[i][pos_q] == in_i.ch);
    end

    if (pos_q == 3'd0) begin
      first_d = in_i.ch;
      minus_d = (in_i.ch == ilp_pkg::CH_MINUS);
      if (ilp_pkg::is_dec(in_i.ch)) begin
        form_d = ilp_pkg::FORM_DEC;
        acc_d  = {{(VALUE_WIDTH-4){1'b0}}, in_i.ch[3:0]};
      end else if ((in_i.ch == ilp_pkg::CH_MINUS) || (in_i.ch == ilp_pkg::CH_PLUS)) begin
        form_d = ilp_pkg::FORM_DEC;
      end else begin
        form_d = ilp_pkg::FORM_OTHER;
      end
    end else begin
      if (pos_q == 3'd1) begin
        second_d = in_i.ch;
      end
      if (form_q == ilp_pkg::FORM_DEC) begin
        if ((pos_q == 3'd1) && (first_q == ilp_pkg::CH_ZERO)
            && ((in_i.ch == ilp_pkg::CH_X_LO) || (in_i.ch == ilp_pkg::CH_X_UP))) begin
          // Leading 0x: switch to the hex path
          form_d  = ilp_pkg::FORM_HEX;
          acc_d   = '0;
          minus_d = 1'b0;
        end else if (!derr_q) begin
          if (ilp_pkg::is_dec(in_i.ch)) begin
            do_acc = 1'b1;
          end else begin
            derr_d = 1'b1;
          end
        end
      end else if ((form_q == ilp_pkg::FORM_HEX) && !derr_q) begin
        if (hexd.hit) begin
          do_acc = 1'b1;
        end else begin
          derr_d = 1'b1;
        end
      end
    end

    // Saturate the accumulator once any carry leaves the value width
    if (do_acc && !ovf_q) begin
      if (acc_sum[SUM_W-1:VALUE_WIDTH] != 4'd0) begin
        ovf_d = 1'b1;
        acc_d = VMAX;
      end else begin
        acc_d = acc_sum[VALUE_WIDTH-1:0];
      end
    end

    if (pos_q != 3'd7) begin
      pos_d = pos_q + 3'd1;
    end
  end

  // Classify the finished token from the updated state
  always_comb begin
    res_ok_d   = 1'b0;
    res_kind_d = ilp_pkg::KIND_NONE;
    res_neg_d  = 1'b0;
    res_val_d  = '0;
    word_hit   = 1'b0;

    case (form_d)
      ilp_pkg::FORM_HEX: begin
        if ((len > 4'd2) && !derr_d) begin
          res_ok_d   = 1'b1;
          res_kind_d = ilp_pkg::KIND_HEX;
          res_val_d  = acc_d;
        end
      end
      ilp_pkg::FORM_DEC: begin
        if (!((len == 4'd1) && !ilp_pkg::is_dec(first_d)) && !derr_d) begin
          res_ok_d   = 1'b1;
          res_kind_d = ilp_pkg::KIND_DEC;
          if (minus_d) begin
            res_neg_d = 1'b1;
            if (ovf_d || (acc_d > NEG_LIM)) begin
              res_val_d = NEG_LIM;
            end else begin
              res_val_d = '0 - acc_d;
            end
          end else begin
            res_val_d = acc_d;
          end
        end
      end
      default: begin
        if ((len == 4'd3) && (first_d == ilp_pkg::CH_QUOTE)
            && (in_i.ch == ilp_pkg::CH_QUOTE)) begin
          res_ok_d   = 1'b1;
          res_kind_d = ilp_pkg::KIND_CHAR;
          res_val_d  = {{(VALUE_WIDTH-8){1'b0}}, second_d};
        end else begin
          // First surviving word of the right length wins
          for (int i = 0; i < ilp_pkg::WORD_COUNT; i++) begin
            if (!word_hit && wmatch_d[i] && (len == ilp_pkg::WORD_LEN[i])) begin
              word_hit   = 1'b1;
              res_ok_d   = 1'b1;
              res_kind_d = ilp_pkg::KIND_BOOL;
              res_val_d  = (i < ilp_pkg::TRUE_WORDS) ? {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : '0;
            end
          end
        end
      end
    endcase
  end

  // Hold token state; restart it after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      form_q   <= ilp_pkg::FORM_OTHER;
      acc_q    <= '0;
      minus_q  <= 1'b0;
      ovf_q    <= 1'b0;
      derr_q   <= 1'b0;
      first_q  <= 8'd0;
      second_q <= 8'd0;
      wmatch_q <= '1;
    end else if (accept) begin
      if (in_i.last) begin
        pos_q    <= 3'd0;
        form_q   <= ilp_pkg::FORM_OTHER;
        acc_q    <= '0;
        minus_q  <= 1'b0;
        ovf_q    <= 1'b0;
        derr_q   <= 1'b0;
        first_q  <= 8'd0;
        second_q <= 8'd0;
        wmatch_q <= '1;
      end else begin
        pos_q    <= pos_d;
        form_q   <= form_d;
        acc_q    <= acc_d;
        minus_q  <= minus_d;
        ovf_q    <= ovf_d;
        derr_q   <= derr_d;
        first_q  <= first_d;
        second_q <= second_d;
        wmatch_q <= wmatch_d;
      end
    end
  end

  // Result beat valid: set on a last character, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (accept && in_i.last) begin
      res_ok_q   <= res_ok_d;
      res_kind_q <= res_kind_d;
      res_neg_q  <= res_neg_d;
      res_val_q  <= res_val_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ok           = res_ok_q;
  assign out_o.literal_kind = res_kind_q;
  assign out_o.negative     = res_neg_q;
  assign out_o.value        = res_val_q;

endmodule
